[src/vt4_pkg.sv]
// ----------------------------------------------------------------------------
// vt4_pkg
// Shared types and constants of the 4x4 vertex transform.
// ----------------------------------------------------------------------------
package vt4_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_PAIRS     = 8;
	localparam int IDX_W         = $clog2(NUM_PAIRS);
	localparam int CFG_W         = 64;
	localparam int Q_W           = 32;
	localparam int PROD_W        = 2 * Q_W;
	localparam int PAIR_W        = PROD_W + 1;
	localparam int SUM_W         = PROD_W + 2;

	localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

	typedef logic signed [Q_W-1:0] q_t;
	typedef q_t [3:0]              vec4_t;
	typedef q_t [15:0]             mat_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

endpackage

[src/vt4_cfg_regs.sv]
// ----------------------------------------------------------------------------
// vt4_cfg_regs
// Matrix storage, column-major, written two entries per register.
// ----------------------------------------------------------------------------
module vt4_cfg_regs
	import vt4_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output mat_t             mat
);

	localparam q_t ONE  = q_t'(1) << FRAC_BITS;
	localparam q_t ZERO = '0;

	// identity: entries 15, 10, 5 and 0
	localparam mat_t MAT_ID = {ONE, {4{ZERO}}, ONE, {4{ZERO}}, ONE, {4{ZERO}}, ONE};

	mat_t mat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= MAT_ID;
		end else if (cfg_we) begin
			mat_q[{cfg_index, 1'b0}] <= cfg_data[Q_W-1:0];
			mat_q[{cfg_index, 1'b1}] <= cfg_data[CFG_W-1:Q_W];
		end
	end

	assign mat = mat_q;

endmodule

[src/vt4_dot_lane.sv]
// ----------------------------------------------------------------------------
// vt4_dot_lane
// One output component: four products, pairwise sums, final sum with
// shift and saturation, over three register stages.
// ----------------------------------------------------------------------------
module vt4_dot_lane
	import vt4_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  pipe_en_t en,
	input  vec4_t    vtx,
	input  vec4_t    col,
	output q_t       res,
	output logic     sat
);

	localparam int HI_W = SUM_W - FRAC_BITS - Q_W + 1;

	logic signed [PROD_W-1:0] prod_s1 [4];
	logic signed [PAIR_W-1:0] pair_s2 [2];
	q_t                       res_s3;
	logic                     sat_s3;

	logic signed [SUM_W-1:0]  total;
	logic [HI_W-1:0]          upper;
	logic                     ovf;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int i = 0; i < 4; i++)
				prod_s1[i] <= $signed(vtx[i]) * $signed(col[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			pair_s2[0] <= PAIR_W'(prod_s1[0]) + PAIR_W'(prod_s1[1]);
			pair_s2[1] <= PAIR_W'(prod_s1[2]) + PAIR_W'(prod_s1[3]);
		end
	end

	always_comb begin
		total = SUM_W'(pair_s2[0]) + SUM_W'(pair_s2[1]);
		upper = total[SUM_W-1:FRAC_BITS+Q_W-1];
		ovf   = !((&upper) || !(|upper));
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sat_s3 <= ovf;
			if (ovf)
				res_s3 <= total[SUM_W-1] ? Q_MIN : Q_MAX;
			else
				res_s3 <= total[FRAC_BITS+Q_W-1:FRAC_BITS];
		end
	end

	assign res = res_s3;
	assign sat = sat_s3;

endmodule

[src/vertex_transform_4x4.sv]
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// Multiplies each vertex by a 4x4 fixed-point matrix held in registers,
// with exact sums, arithmetic shift and saturation per component.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_x in_y in_z in_w
//   out      output     out_valid / out_stall out_x out_y out_z out_w clipped
//   cfg      input      cfg_we                cfg_index cfg_data
//
// one item per cycle while the output is not stalled; each item passes the
// multiply, pairwise-add and final add/saturate stage registers in turn
// before out_valid rises.
// reset clears the stage valid bits and loads the identity matrix.
// a stalled output holds; empty stages still fill, so in_stall rises only
// when all three stages hold items.
// ----------------------------------------------------------------------------
module vertex_transform_4x4
	import vt4_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  q_t               in_x,
	input  q_t               in_y,
	input  q_t               in_z,
	input  q_t               in_w,
	output logic             out_valid,
	input  logic             out_stall,
	output q_t               out_x,
	output q_t               out_y,
	output q_t               out_z,
	output q_t               out_w,
	output logic             clipped
);

	mat_t     mat;
	vec4_t    vtx;
	vec4_t    res;
	logic     [3:0] sat;
	pipe_en_t en;
	logic     valid_s1, valid_s2, valid_s3;

	vt4_cfg_regs #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mat       (mat)
	);

	assign vtx = {in_w, in_z, in_y, in_x};

	for (genvar j = 0; j < 4; j++) begin : g_lane
		vt4_dot_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk (clk),
			.en  (en),
			.vtx (vtx),
			.col ({mat[12+j], mat[8+j], mat[4+j], mat[j]}),
			.res (res[j]),
			.sat (sat[j])
		);
	end

	always_comb begin
		en.s3 = !valid_s3 || !out_stall;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en.s1)
				valid_s1 <= in_valid;
			if (en.s2)
				valid_s2 <= valid_s1;
			if (en.s3)
				valid_s3 <= valid_s2;
		end
	end

	assign in_stall  = !en.s1;
	assign out_valid = valid_s3;
	assign out_x     = res[0];
	assign out_y     = res[1];
	assign out_z     = res[2];
	assign out_w     = res[3];
	assign clipped   = |sat;

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && out_stall))
		else $error("input stalled with a free stage");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !en.s3) |=> valid_s2)
		else $error("stage two item lost under stall");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped) |->
			(out_x == Q_MAX || out_x == Q_MIN || out_y == Q_MAX || out_y == Q_MIN ||
			 out_z == Q_MAX || out_z == Q_MIN || out_w == Q_MAX || out_w == Q_MIN))
		else $error("clipped set without a saturated component");
`endif

endmodule
